/* hdl/c8x_pkg.sv */
// Shared types, constants and codes for the CHIP-8 instruction executor.
// No dependencies; the top level and c8x_exec import this package, c8x_ram does not.
package c8x_pkg;

   localparam int MEM_BYTES     = 4096;
   localparam int ADDR_W        = $clog2(MEM_BYTES);
   localparam int STACK_DEPTH   = 16;
   localparam int SP_W          = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int SCREEN_WIDTH  = 64;
   localparam int SCREEN_HEIGHT = 32;

   localparam logic [2:0] ACT_LOAD    = 3'd0;
   localparam logic [2:0] ACT_READ    = 3'd1;
   localparam logic [2:0] ACT_STEP    = 3'd2;
   localparam logic [2:0] ACT_DRAWN   = 3'd3;
   localparam logic [2:0] ACT_RESTART = 3'd4;

   localparam logic CSR_PROG_START = 1'b0;
   localparam logic CSR_FONT_BASE  = 1'b1;

   localparam logic [3:0] OP_SYS  = 4'h0;
   localparam logic [3:0] OP_JP   = 4'h1;
   localparam logic [3:0] OP_CALL = 4'h2;
   localparam logic [3:0] OP_SE   = 4'h3;
   localparam logic [3:0] OP_SNE  = 4'h4;
   localparam logic [3:0] OP_SER  = 4'h5;
   localparam logic [3:0] OP_LDK  = 4'h6;
   localparam logic [3:0] OP_ADDK = 4'h7;
   localparam logic [3:0] OP_ALU  = 4'h8;
   localparam logic [3:0] OP_SNER = 4'h9;
   localparam logic [3:0] OP_LDI  = 4'hA;
   localparam logic [3:0] OP_JPV0 = 4'hB;
   localparam logic [3:0] OP_RND  = 4'hC;
   localparam logic [3:0] OP_DRW  = 4'hD;
   localparam logic [3:0] OP_KEY  = 4'hE;
   localparam logic [3:0] OP_MISC = 4'hF;

   localparam logic [15:0] OPW_CLS = 16'h00E0;
   localparam logic [15:0] OPW_RET = 16'h00EE;

   localparam logic [3:0] ALU_MOV = 4'h0;
   localparam logic [3:0] ALU_OR  = 4'h1;
   localparam logic [3:0] ALU_AND = 4'h2;
   localparam logic [3:0] ALU_XOR = 4'h3;
   localparam logic [3:0] ALU_ADD = 4'h4;
   localparam logic [3:0] ALU_SUB = 4'h5;
   localparam logic [3:0] ALU_SHR = 4'h6;
   localparam logic [3:0] ALU_SBN = 4'h7;
   localparam logic [3:0] ALU_SHL = 4'hE;

   localparam logic [7:0] KEY_DOWN = 8'h9E;
   localparam logic [7:0] KEY_UP   = 8'hA1;

   localparam logic [7:0] FN_GETDT = 8'h07;
   localparam logic [7:0] FN_WAIT  = 8'h0A;
   localparam logic [7:0] FN_SETDT = 8'h15;
   localparam logic [7:0] FN_SETST = 8'h18;
   localparam logic [7:0] FN_ADDI  = 8'h1E;
   localparam logic [7:0] FN_FONT  = 8'h29;
   localparam logic [7:0] FN_BCD   = 8'h33;
   localparam logic [7:0] FN_STORE = 8'h55;
   localparam logic [7:0] FN_LOAD  = 8'h65;

   typedef struct packed {
      logic        collision;
      logic [7:0]  random_byte;
      logic [15:0] keys_down;
      logic [7:0]  write_data;
      logic [11:0] address;
      logic [2:0]  action;
   } req_type;

   typedef struct packed {
      logic        waiting_key;
      logic        sound_on;
      logic [15:0] sprite_address;
      logic [3:0]  draw_rows;
      logic [4:0]  draw_y;
      logic [5:0]  draw_x;
      logic        draw_request;
      logic        clear_request;
      logic [11:0] program_counter;
      logic [7:0]  read_data;
   } rsp_type;

endpackage

/* hdl/chip8_instruction_executor_top.sv */
// A result waits in the done state until the output is free to take it.
// One request is handled at a time; the next is taken as soon as the last one's result is registered.
// Reset (synchronous) sets pc to 512, clears registers, index, stack pointer and timers.
// Top level: configuration registers and stream packing; uses c8x_pkg and c8x_exec.
module chip8_instruction_executor_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // address, write_data, keys_down, random_byte, collision
   input  logic [2:0]  req_tuser,   // action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // read_data, program_counter, clear_request,
                                    // draw_request, draw_x, draw_y, draw_rows,
                                    // sprite_address, sound_on, waiting_key
   input  logic        csr_wen,
   input  logic [0:0]  csr_index,
   input  logic [11:0] csr_wdata
);
   import c8x_pkg::*;

   logic [11:0] start_ff, font_ff;
   req_type     req;
   rsp_type     rsp;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= 12'd512;
         font_ff  <= 12'd80;
      end else if (csr_wen) begin
         case (csr_index[0])
            CSR_PROG_START: start_ff <= csr_wdata;
            CSR_FONT_BASE:  font_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign req.action      = req_tuser;
   assign req.address     = req_tdata[11:0];
   assign req.write_data  = req_tdata[19:12];
   assign req.keys_down   = req_tdata[35:20];
   assign req.random_byte = req_tdata[43:36];
   assign req.collision   = req_tdata[44];

   assign rsp_tdata = {1'b0, rsp};

   c8x_exec u_exec (
      .clock         (clock),
      .reset         (reset),
      .program_start (start_ff),
      .font_base     (font_ff),
      .req_valid     (req_tvalid),
      .req_ready     (req_tready),
      .req           (req),
      .rsp_valid     (rsp_tvalid),
      .rsp_ready     (rsp_tready),
      .rsp           (rsp)
   );

endmodule

/* hdl/c8x_ram.sv */
// Generic synchronous RAM: one write port, one read port, registered read data.
// No dependencies.
module c8x_ram #(
   parameter int ADDR_BITS = 4,
   parameter int DATA_BITS = 8
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [DATA_BITS-1:0] wr_data,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [DATA_BITS-1:0] rd_data
);

   logic [DATA_BITS-1:0] mem [2**ADDR_BITS];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

/* hdl/c8x_exec.sv */
// Request sequencer of the executor: fetch, decode, execute and result register.
// Uses c8x_pkg and three c8x_ram instances (program memory, registers, stack).
module c8x_exec (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [11:0]           program_start,
   input  logic [11:0]           font_base,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  c8x_pkg::req_type      req,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output c8x_pkg::rsp_type      rsp
);
   import c8x_pkg::*;

   localparam logic [4:0] ST_IDLE = 5'd0;
   localparam logic [4:0] ST_MRD  = 5'd1;
   localparam logic [4:0] ST_F1   = 5'd2;
   localparam logic [4:0] ST_F2   = 5'd3;
   localparam logic [4:0] ST_F3   = 5'd4;
   localparam logic [4:0] ST_F4   = 5'd5;
   localparam logic [4:0] ST_EX   = 5'd6;
   localparam logic [4:0] ST_RET  = 5'd7;
   localparam logic [4:0] ST_FLAG = 5'd8;
   localparam logic [4:0] ST_BCD1 = 5'd9;
   localparam logic [4:0] ST_BCD2 = 5'd10;
   localparam logic [4:0] ST_STR  = 5'd11;
   localparam logic [4:0] ST_STW  = 5'd12;
   localparam logic [4:0] ST_LDR  = 5'd13;
   localparam logic [4:0] ST_LDW  = 5'd14;
   localparam logic [4:0] ST_DONE = 5'd15;

   localparam logic [SP_W-1:0] SP_LAST = SP_W'(STACK_DEPTH - 1);

   function automatic logic [7:0] mod_const(input logic [7:0] v, input logic [8:0] m);
      logic [8:0] r;
      r = {1'b0, v};
      for (int k = 0; k < 8; k++) begin
         if (r >= m) begin
            r = r - m;
         end
      end
      return r[7:0];
   endfunction

   logic [4:0]       state_ff, state_in;
   logic [15:0]      op_ff, op_in;
   logic [7:0]       vx_ff, vx_in, vy_ff, vy_in;
   logic [11:0]      pc_ff, pc_in;
   logic [15:0]      idx_ff, idx_in;
   logic [SP_W-1:0]  sp_ff, sp_in;
   logic [7:0]       dt_ff, dt_in, st_ff, st_in;
   logic [3:0]       cnt_ff, cnt_in;
   logic             flag_ff, flag_in;
   logic [3:0]       tens_ff, tens_in, hund_ff, hund_in;
   logic [15:0]      keys_ff, keys_in;
   logic [7:0]       rnd_ff, rnd_in;
   rsp_type          res_ff, res_in;
   rsp_type          rsp_ff, rsp_in;
   logic             rv_ff, rv_in;
   logic [15:0]      rvld_ff;
   logic             rdv_ff;

   logic             mw_en;
   logic [11:0]      mw_addr, mr_addr;
   logic [7:0]       mw_data, m_rdata;
   logic             rw_en;
   logic [3:0]       rw_addr, rr_addr;
   logic [7:0]       rw_data, r_ram, r_rdata;
   logic             sk_we;
   logic [SP_W-1:0]  sk_waddr, sk_raddr;
   logic [11:0]      sk_wdata, sk_rdata;

   logic [3:0]       x, y, n;
   logic [7:0]       kk;
   logic [11:0]      nnn, pcn, ixc;
   logic [SP_W-1:0]  sp_inc, sp_dec;
   logic [8:0]       sum9;
   logic [7:0]       rem, ones;
   logic [14:0]      tprod;
   logic [3:0]       tens, hund, lowkey;
   logic             accept;

   assign x      = op_ff[11:8];
   assign y      = op_ff[7:4];
   assign n      = op_ff[3:0];
   assign kk     = op_ff[7:0];
   assign nnn    = op_ff[11:0];
   assign pcn    = pc_ff + 12'd2;
   assign ixc    = idx_ff[11:0] + {8'd0, cnt_ff};
   assign sp_inc = (sp_ff == SP_LAST) ? '0 : sp_ff + 1'b1;
   assign sp_dec = (sp_ff == '0) ? SP_LAST : sp_ff - 1'b1;
   assign sum9   = {1'b0, vx_ff} + {1'b0, vy_ff};
   assign r_rdata = rdv_ff ? r_ram : 8'd0;

   assign hund  = (vx_ff >= 8'd200) ? 4'd2 : ((vx_ff >= 8'd100) ? 4'd1 : 4'd0);
   assign rem   = vx_ff - ({4'd0, hund} * 8'd100);
   assign tprod = {7'd0, rem} * 15'd205;
   assign tens  = tprod[14:11];
   assign ones  = rem - {tens, 3'd0} - {3'd0, tens, 1'b0};

   always_comb begin
      lowkey = 4'd0;
      for (int k = 15; k >= 0; k--) begin
         if (keys_ff[k]) begin
            lowkey = 4'(k);
         end
      end
   end

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rv_ff;
   assign rsp       = rsp_ff;

   always_comb begin
      case (state_ff)
         ST_IDLE: mr_addr = (req.action == ACT_READ) ? req.address : pc_ff;
         ST_F1:   mr_addr = pc_ff + 12'd1;
         ST_LDR:  mr_addr = ixc;
         default: mr_addr = pc_ff;
      endcase
      case (state_ff)
         ST_F2:   rr_addr = x;
         ST_F3:   rr_addr = y;
         ST_F4:   rr_addr = 4'd0;
         ST_STR:  rr_addr = cnt_ff;
         default: rr_addr = x;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      vx_in    = vx_ff;
      vy_in    = vy_ff;
      pc_in    = pc_ff;
      idx_in   = idx_ff;
      sp_in    = sp_ff;
      dt_in    = dt_ff;
      st_in    = st_ff;
      cnt_in   = cnt_ff;
      flag_in  = flag_ff;
      tens_in  = tens_ff;
      hund_in  = hund_ff;
      keys_in  = keys_ff;
      rnd_in   = rnd_ff;
      res_in   = res_ff;
      rsp_in   = rsp_ff;
      rv_in    = rv_ff && !rsp_ready;
      mw_en    = 1'b0;
      mw_addr  = ixc;
      mw_data  = r_rdata;
      rw_en    = 1'b0;
      rw_addr  = x;
      rw_data  = 8'd0;
      sk_we    = 1'b0;
      sk_waddr = sp_ff;
      sk_wdata = pcn;
      sk_raddr = sp_dec;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               keys_in  = req.keys_down;
               rnd_in   = req.random_byte;
               res_in   = '0;
               state_in = ST_DONE;
               case (req.action)
                  ACT_LOAD: begin
                     mw_en   = 1'b1;
                     mw_addr = req.address;
                     mw_data = req.write_data;
                  end
                  ACT_READ:    state_in = ST_MRD;
                  ACT_STEP:    state_in = ST_F1;
                  ACT_DRAWN: begin
                     rw_en   = 1'b1;
                     rw_addr = 4'hF;
                     rw_data = {7'd0, req.collision};
                  end
                  ACT_RESTART: pc_in = program_start;
                  default: ;
               endcase
            end
         end
         ST_MRD: begin
            res_in.read_data = m_rdata;
            state_in = ST_DONE;
         end
         ST_F1: begin
            op_in[15:8] = m_rdata;
            state_in = ST_F2;
         end
         ST_F2: begin
            op_in[7:0] = m_rdata;
            state_in = ST_F3;
         end
         ST_F3: begin
            vx_in = r_rdata;
            state_in = ST_F4;
         end
         ST_F4: begin
            vy_in = r_rdata;
            state_in = ST_EX;
         end
         ST_EX: begin
            pc_in    = pcn;
            state_in = ST_DONE;
            dt_in    = (dt_ff != 8'd0) ? dt_ff - 8'd1 : 8'd0;
            st_in    = (st_ff != 8'd0) ? st_ff - 8'd1 : 8'd0;
            rw_addr  = x;
            case (op_ff[15:12])
               OP_SYS: begin
                  if (op_ff == OPW_CLS) begin
                     res_in.clear_request = 1'b1;
                  end else if (op_ff == OPW_RET) begin
                     sp_in    = sp_dec;
                     state_in = ST_RET;
                  end
               end
               OP_JP: pc_in = nnn;
               OP_CALL: begin
                  sk_we = 1'b1;
                  sp_in = sp_inc;
                  pc_in = nnn;
               end
               OP_SE:   if (vx_ff == kk) pc_in = pcn + 12'd2;
               OP_SNE:  if (vx_ff != kk) pc_in = pcn + 12'd2;
               OP_SER:  if (vx_ff == vy_ff) pc_in = pcn + 12'd2;
               OP_SNER: if (vx_ff != vy_ff) pc_in = pcn + 12'd2;
               OP_LDK: begin
                  rw_en   = 1'b1;
                  rw_data = kk;
               end
               OP_ADDK: begin
                  rw_en   = 1'b1;
                  rw_data = vx_ff + kk;
               end
               OP_ALU: begin
                  rw_en = 1'b1;
                  case (n)
                     ALU_MOV: rw_data = vy_ff;
                     ALU_OR:  rw_data = vx_ff | vy_ff;
                     ALU_AND: rw_data = vx_ff & vy_ff;
                     ALU_XOR: rw_data = vx_ff ^ vy_ff;
                     ALU_ADD: begin
                        rw_data  = sum9[7:0];
                        flag_in  = sum9[8];
                        state_in = ST_FLAG;
                     end
                     ALU_SUB: begin
                        rw_data  = vx_ff - vy_ff;
                        flag_in  = (vx_ff >= vy_ff);
                        state_in = ST_FLAG;
                     end
                     ALU_SHR: begin
                        rw_data  = {1'b0, vx_ff[7:1]};
                        flag_in  = vx_ff[0];
                        state_in = ST_FLAG;
                     end
                     ALU_SBN: begin
                        rw_data  = vy_ff - vx_ff;
                        flag_in  = (vy_ff >= vx_ff);
                        state_in = ST_FLAG;
                     end
                     ALU_SHL: begin
                        rw_data  = {vx_ff[6:0], 1'b0};
                        flag_in  = vx_ff[7];
                        state_in = ST_FLAG;
                     end
                     default: rw_en = 1'b0;
                  endcase
               end
               OP_LDI:  idx_in = {4'd0, nnn};
               OP_JPV0: pc_in = nnn + {4'd0, r_rdata};
               OP_RND: begin
                  rw_en   = 1'b1;
                  rw_data = kk & rnd_ff;
               end
               OP_DRW: begin
                  res_in.draw_request   = 1'b1;
                  res_in.draw_x         = 6'(mod_const(vx_ff, 9'(SCREEN_WIDTH)));
                  res_in.draw_y         = 5'(mod_const(vy_ff, 9'(SCREEN_HEIGHT)));
                  res_in.draw_rows      = n;
                  res_in.sprite_address = idx_ff;
               end
               OP_KEY: begin
                  if (kk == KEY_DOWN) begin
                     if (vx_ff[7:4] == 4'd0 && keys_ff[vx_ff[3:0]]) pc_in = pcn + 12'd2;
                  end else if (kk == KEY_UP) begin
                     if (!(vx_ff[7:4] == 4'd0 && keys_ff[vx_ff[3:0]])) pc_in = pcn + 12'd2;
                  end
               end
               default: begin
                  case (kk)
                     FN_GETDT: begin
                        rw_en   = 1'b1;
                        rw_data = dt_ff;
                     end
                     FN_WAIT: begin
                        if (keys_ff != 16'd0) begin
                           rw_en   = 1'b1;
                           rw_data = {4'd0, lowkey};
                        end else begin
                           pc_in = pc_ff;
                           res_in.waiting_key = 1'b1;
                        end
                     end
                     FN_SETDT: dt_in = (vx_ff != 8'd0) ? vx_ff - 8'd1 : 8'd0;
                     FN_SETST: st_in = (vx_ff != 8'd0) ? vx_ff - 8'd1 : 8'd0;
                     FN_ADDI:  idx_in = idx_ff + {8'd0, vx_ff};
                     FN_FONT:  idx_in = {4'd0, font_base} + {6'd0, vx_ff, 2'b00}
                                        + {8'd0, vx_ff};
                     FN_BCD: begin
                        mw_en    = 1'b1;
                        mw_addr  = idx_ff[11:0] + 12'd2;
                        mw_data  = ones;
                        tens_in  = tens;
                        hund_in  = hund;
                        state_in = ST_BCD1;
                     end
                     FN_STORE: begin
                        cnt_in   = 4'd0;
                        state_in = ST_STR;
                     end
                     FN_LOAD: begin
                        cnt_in   = 4'd0;
                        state_in = ST_LDR;
                     end
                     default: ;
                  endcase
               end
            endcase
         end
         ST_RET: begin
            pc_in    = sk_rdata;
            state_in = ST_DONE;
         end
         ST_FLAG: begin
            rw_en    = 1'b1;
            rw_addr  = 4'hF;
            rw_data  = {7'd0, flag_ff};
            state_in = ST_DONE;
         end
         ST_BCD1: begin
            mw_en    = 1'b1;
            mw_addr  = idx_ff[11:0] + 12'd1;
            mw_data  = {4'd0, tens_ff};
            state_in = ST_BCD2;
         end
         ST_BCD2: begin
            mw_en    = 1'b1;
            mw_addr  = idx_ff[11:0];
            mw_data  = {4'd0, hund_ff};
            state_in = ST_DONE;
         end
         ST_STR: state_in = ST_STW;
         ST_STW: begin
            mw_en   = 1'b1;
            cnt_in  = cnt_ff + 4'd1;
            state_in = (cnt_ff == x) ? ST_DONE : ST_STR;
         end
         ST_LDR: state_in = ST_LDW;
         ST_LDW: begin
            rw_en   = 1'b1;
            rw_addr = cnt_ff;
            rw_data = m_rdata;
            cnt_in  = cnt_ff + 4'd1;
            state_in = (cnt_ff == x) ? ST_DONE : ST_LDR;
         end
         ST_DONE: begin
            if (!rv_ff || rsp_ready) begin
               rsp_in = res_ff;
               rsp_in.program_counter = pc_ff;
               rsp_in.sound_on = (st_ff != 8'd0);
               rv_in    = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pc_ff    <= 12'd512;
         idx_ff   <= 16'd0;
         sp_ff    <= '0;
         dt_ff    <= 8'd0;
         st_ff    <= 8'd0;
         rv_ff    <= 1'b0;
         rvld_ff  <= 16'd0;
         rdv_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         pc_ff    <= pc_in;
         idx_ff   <= idx_in;
         sp_ff    <= sp_in;
         dt_ff    <= dt_in;
         st_ff    <= st_in;
         rv_ff    <= rv_in;
         rdv_ff   <= rvld_ff[rr_addr];
         if (rw_en) begin
            rvld_ff[rw_addr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      vx_ff   <= vx_in;
      vy_ff   <= vy_in;
      cnt_ff  <= cnt_in;
      flag_ff <= flag_in;
      tens_ff <= tens_in;
      hund_ff <= hund_in;
      keys_ff <= keys_in;
      rnd_ff  <= rnd_in;
      res_ff  <= res_in;
      rsp_ff  <= rsp_in;
   end

   c8x_ram #(.ADDR_BITS(ADDR_W), .DATA_BITS(8)) u_prog_mem (
      .clock   (clock),
      .wr_en   (mw_en),
      .wr_addr (mw_addr),
      .wr_data (mw_data),
      .rd_addr (mr_addr),
      .rd_data (m_rdata)
   );

   c8x_ram #(.ADDR_BITS(4), .DATA_BITS(8)) u_regs (
      .clock   (clock),
      .wr_en   (rw_en),
      .wr_addr (rw_addr),
      .wr_data (rw_data),
      .rd_addr (rr_addr),
      .rd_data (r_ram)
   );

   c8x_ram #(.ADDR_BITS(SP_W), .DATA_BITS(12)) u_stack (
      .clock   (clock),
      .wr_en   (sk_we),
      .wr_addr (sk_waddr),
      .wr_data (sk_wdata),
      .rd_addr (sk_raddr),
      .rd_data (sk_rdata)
   );

   a_sp_range: assert property (@(posedge clock) disable iff (reset)
      sp_ff <= SP_LAST) else $error("stack pointer beyond stack depth");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff != ST_IDLE) else $error("accepted request left no work");

   a_done_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && rv_ff && !rsp_ready) |=> state_ff == ST_DONE)
      else $error("result dropped while output held");

endmodule
